FILE: rtl/core/assert_macros.svh
// concurrent assertion helpers, clocked on clk and quiet during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a plain check that must hold at every clock edge out of reset
`define CHECK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent now implies consequent in the next cycle
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/actr_pkg.sv
package actr_pkg;

  localparam int unsigned TAG_LEN  = 24;
  localparam logic [4:0]  LAST_POS = 5'd23;
  localparam logic [2:0]  SEG_OPEN  = 3'd0;
  localparam logic [2:0]  SEG_RED   = 3'd1;
  localparam logic [2:0]  SEG_GREEN = 3'd2;
  localparam logic [2:0]  SEG_BLUE  = 3'd3;
  localparam logic [2:0]  SEG_ALPHA = 3'd4;
  localparam logic [2:0]  SEG_CLOSE = 3'd5;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_HL     = 8'h68;
  localparam logic [7:0] CH_C      = 8'h63;

  localparam logic [7:0] UTF_LEAD = 8'hC0;
  localparam logic [7:0] UTF_CONT = 8'h80;
  localparam logic [5:0] UTF_LOW  = 6'h3F;

  // one emit job handed from the matcher to the emitter
  typedef struct packed {
    logic            is_tag;   // replacement sequence instead of a flush
    logic [4:0]      count;    // held bytes to flush
    logic            append;   // send ch after the held bytes
    logic [7:0]      ch;
    logic            last;
    logic [7:0][7:0] hex;      // snapshot of the held hex digits
  } job_t;

  // literal byte of the tag shape at a position (hex slots read as zero)
  function automatic logic [7:0] tag_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0:    r = CH_LBRACE;
      5'd1:    r = CH_BSLASH;
      5'd2:    r = CH_A;
      5'd3:    r = CH_L;
      5'd4:    r = CH_P;
      5'd5:    r = CH_HL;
      5'd6:    r = CH_A;
      5'd7:    r = CH_AMP;
      5'd8:    r = CH_H;
      5'd11:   r = CH_AMP;
      5'd12:   r = CH_BSLASH;
      5'd13:   r = CH_C;
      5'd14:   r = CH_AMP;
      5'd15:   r = CH_H;
      5'd22:   r = CH_AMP;
      5'd23:   r = CH_RBRACE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic hex_pos(input logic [4:0] p);
    return (p == 5'd9) || (p == 5'd10) || ((p >= 5'd16) && (p <= 5'd21));
  endfunction

  // alpha digits go to slots 0..1, color digits to slots 2..7
  function automatic logic [2:0] hex_slot(input logic [4:0] p);
    logic [4:0] d;
    d = p - 5'd14;
    if (p == 5'd9) return 3'd0;
    if (p == 5'd10) return 3'd1;
    return d[2:0];
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] r;
    if (c <= 8'h39) r = c[3:0];
    else            r = c[3:0] + 4'd9;
    return r;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_nibble(hi), hex_nibble(lo)};
  endfunction

endpackage

FILE: rtl/core/actr_matcher.sv
module actr_matcher (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     ch,
  input  logic           last,
  output logic           needs_job,
  output actr_pkg::job_t job
);
  import actr_pkg::*;

  `include "assert_macros.svh"

  logic [4:0]      pos;
  logic [4:0]      pos_next;
  logic [7:0][7:0] hex;
  logic            fit;
  logic            at_end;

  assign fit    = hex_pos(pos) ? is_hex(ch) : (ch == tag_char(pos));
  assign at_end = (pos == LAST_POS);

  always_comb begin
    job.is_tag = 1'b0;
    job.count  = pos;
    job.append = 1'b0;
    job.ch     = ch;
    job.last   = last;
    job.hex    = hex;
    needs_job  = 1'b0;
    pos_next   = pos;
    if (fit && at_end) begin
      job.is_tag = 1'b1;
      needs_job  = 1'b1;
      pos_next   = 5'd0;
    end else if (fit) begin
      // still inside the tag; the end of text flushes everything
      if (last) begin
        job.append = 1'b1;
        needs_job  = 1'b1;
        pos_next   = 5'd0;
      end else begin
        pos_next = pos + 5'd1;
      end
    end else begin
      // broken match: a brace restarts unless the text ends, otherwise the byte goes out as is
      job.append = last || (ch != CH_LBRACE);
      needs_job  = job.append || (pos != 5'd0);
      pos_next   = ((ch == CH_LBRACE) && !last) ? 5'd1 : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 5'd0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fit && !at_end && hex_pos(pos)) begin
      hex[hex_slot(pos)] <= ch;
    end
  end

  `CHECK_ALWAYS(a_pos_range, pos <= LAST_POS, "match position past tag end")
  `CHECK_NEXT(a_tag_clears, take && fit && at_end, pos == 5'd0, "tag done but match open")

endmodule

FILE: rtl/core/actr_emitter.sv
module actr_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  actr_pkg::job_t job_in,
  output logic           job_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     char_out,
  output logic           last_out
);
  import actr_pkg::*;

  `include "assert_macros.svh"

  logic       active;
  job_t       job;
  logic [4:0] idx;
  logic       sub;
  logic       o_valid;
  logic [7:0] o_char;
  logic       o_last;

  logic       out_move;
  logic [4:0] total;
  logic [2:0] seg;
  logic [7:0] val;
  logic [7:0] tag_byte;
  logic       seg_done;
  logic [7:0] flush_byte;
  logic [7:0] cur_byte;
  logic       at_end;

  assign out_move = !o_valid || !out_stall;
  assign total    = job.count + {4'd0, job.append};
  assign seg      = idx[2:0];

  always_comb begin
    case (seg)
      SEG_RED:   val = pair_value(job.hex[6], job.hex[7]);
      SEG_GREEN: val = pair_value(job.hex[4], job.hex[5]);
      SEG_BLUE:  val = pair_value(job.hex[2], job.hex[3]);
      SEG_ALPHA: val = ~pair_value(job.hex[0], job.hex[1]);
      default:   val = 8'h00;
    endcase
  end

  always_comb begin
    if (seg == SEG_OPEN) begin
      tag_byte = CH_LBRACE;
      seg_done = 1'b1;
    end else if (seg == SEG_CLOSE) begin
      tag_byte = CH_RBRACE;
      seg_done = 1'b1;
    end else if (!val[7]) begin
      tag_byte = val;
      seg_done = 1'b1;
    end else if (!sub) begin
      tag_byte = UTF_LEAD | {6'd0, val[7:6]};
      seg_done = 1'b0;
    end else begin
      tag_byte = UTF_CONT | {2'd0, val[5:0] & UTF_LOW};
      seg_done = 1'b1;
    end
  end

  always_comb begin
    if (idx < job.count) begin
      flush_byte = hex_pos(idx) ? job.hex[hex_slot(idx)] : tag_char(idx);
    end else begin
      flush_byte = job.ch;
    end
  end

  assign cur_byte  = job.is_tag ? tag_byte : flush_byte;
  assign at_end    = job.is_tag ? ((seg == SEG_CLOSE) && seg_done) : (idx == total - 5'd1);
  assign job_ready = !active || (out_move && at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (out_move) begin
        o_valid <= active;
      end
      if (load) begin
        active <= 1'b1;
      end else if (active && out_move && at_end) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      o_char <= cur_byte;
      o_last <= job.last && at_end;
    end
    if (load) begin
      job <= job_in;
      idx <= 5'd0;
      sub <= 1'b0;
    end else if (active && out_move) begin
      if (!job.is_tag || seg_done) begin
        idx <= idx + 5'd1;
        sub <= 1'b0;
      end else begin
        sub <= 1'b1;
      end
    end
  end

  assign out_valid = o_valid;
  assign char_out  = o_char;
  assign last_out  = o_last;

  `CHECK_ALWAYS(a_flush_idx, !(active && !job.is_tag) || (idx < total), "flush index overrun")
  `CHECK_ALWAYS(a_tag_idx, !(active && job.is_tag) || (seg <= SEG_CLOSE), "tag segment overrun")

endmodule

FILE: rtl/core/alpha_color_tag_rewriter.sv
// alpha_color_tag_rewriter
// input channel: in_valid / in_stall with char_in and last_in, one text byte per word
// output channel: out_valid / out_stall with char_out and last_out, one byte per word
// every tag {\alpha&HAA&\c&HBBGGRR&} (hex in either case) becomes '{', red, green,
// blue and 255-AA as one- or two-byte utf-8 code points, then '}'
// bytes of a partial tag are held back and sent unchanged when the match breaks
// or when last_in closes the text; last_out marks the final byte for that word
// a byte that passes straight through goes from the input register through the
// emitter job register to the output register
// throughput: one input word per cycle while out_stall is low and each word gives
// at most one output word; a word that yields n output words holds the input until
// all n are sent, as the emitter sends one byte per cycle from its job register
// in_stall comes from a two-entry skid register, so it never depends on
// out_stall in the same cycle
// reset (rst, synchronous) clears the match and drops any queued words
// while out_stall is high the output word holds and the input backs up
module alpha_color_tag_rewriter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       last_out
);
  import actr_pkg::*;

  `include "assert_macros.svh"

  // main input register and skid register
  logic       v0;
  logic [7:0] c0;
  logic       l0;
  logic       v1;
  logic [7:0] c1;
  logic       l1;

  logic       accept;
  logic       take;
  logic       needs_job;
  logic       job_ready;
  job_t       job;

  assign in_stall = v1;
  assign accept   = in_valid && !v1;
  // a word leaves the input register when it needs no job or the emitter can take its job
  assign take     = v0 && (!needs_job || job_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (v1) begin
      if (take) begin
        v1 <= 1'b0;
      end
    end else if (accept) begin
      if (v0 && !take) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end else if (take) begin
      v0 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      if (take) begin
        c0 <= c1;
        l0 <= l1;
      end
    end else if (accept) begin
      if (v0 && !take) begin
        c1 <= char_in;
        l1 <= last_in;
      end else begin
        c0 <= char_in;
        l0 <= last_in;
      end
    end
  end

  actr_matcher u_matcher (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .ch        (c0),
    .last      (l0),
    .needs_job (needs_job),
    .job       (job)
  );

  actr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (take && needs_job),
    .job_in    (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last_out  (last_out)
  );

  `CHECK_ALWAYS(a_skid_order, !v1 || v0, "skid word without main word")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import actr_pkg::CH_LBRACE;
  import actr_pkg::CH_RBRACE;
  import actr_pkg::TAG_LEN;

  // shape of the tag, 'x' marks a hex digit slot
  localparam string TAG_SHAPE = "{\\alpha&Hxx&\\c&Hxxxxxx&}";
  localparam int RANDOM_WORDS = 245;

  // one text byte as it crosses either channel
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_word_t;

  // receiver stall behavior, switched whenever its random mode counter runs out
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       last_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic       last_out;

  alpha_color_tag_rewriter dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_in  (char_in),
    .last_in  (last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_out (char_out),
    .last_out (last_out)
  );

  always #6 clk = ~clk;

  // text waiting to be sent, and the rewritten bytes still owed by the block
  text_word_t text_q[$];
  text_word_t rewritten_q[$];
  int errors = 0;

  // ---------------------------------------------------------------------------
  // rewrite predictor: own copy of the matcher state
  // ---------------------------------------------------------------------------
  int         tag_pos = 0;       // tag bytes matched and held so far
  logic [7:0] held [0:22];       // held tag bytes, valid below tag_pos

  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c <= "9") return 4'(c - "0");
    if (c >= "a") return 4'(c - "a" + 10);
    return 4'(c - "A" + 10);
  endfunction

  // does byte c continue the tag at position p
  function automatic bit tag_fits(input int p, input logic [7:0] c);
    logic [7:0] want;
    if (p >= TAG_LEN) return 1'b0;
    want = TAG_SHAPE[p];
    if (want == "x") return is_hex_digit(c);
    return c == want;
  endfunction

  function automatic void owe_byte(input logic [7:0] c);
    text_word_t w;
    w.ch  = c;
    w.fin = 1'b0;
    rewritten_q = {rewritten_q, w};
  endfunction

  // one value as a one- or two-byte utf-8 code point
  function automatic void owe_code_point(input logic [7:0] v);
    if (v < 8'h80) owe_byte(v);
    else begin
      owe_byte(8'hC0 | {6'd0, v[7:6]});
      owe_byte(8'h80 | {2'd0, v[5:0]});
    end
  endfunction

  // held bytes go out as they came in
  function automatic void release_held();
    for (int i = 0; i < tag_pos; i++) owe_byte(held[i]);
    tag_pos = 0;
  endfunction

  function automatic logic [7:0] held_pair(input int at);
    return {digit_value(held[at]), digit_value(held[at + 1])};
  endfunction

  // all bytes owed for one accepted input word
  function automatic void rewrite_byte(input logic [7:0] c, input logic fin);
    int         first;
    text_word_t tail;
    first = rewritten_q.size();
    if (tag_fits(tag_pos, c)) begin
      if (tag_pos == TAG_LEN - 1) begin
        // complete tag: red, green, blue, then inverted alpha
        owe_byte(CH_LBRACE);
        owe_code_point(held_pair(20));
        owe_code_point(held_pair(18));
        owe_code_point(held_pair(16));
        owe_code_point(8'hFF - held_pair(9));
        owe_byte(CH_RBRACE);
        tag_pos = 0;
      end else begin
        held[tag_pos] = c;
        tag_pos++;
      end
    end else begin
      // broken match: flush, then the breaking byte may start a new tag
      release_held();
      if (c == CH_LBRACE) begin
        held[0] = c;
        tag_pos = 1;
      end else owe_byte(c);
    end
    if (fin) begin
      // end of text closes any open match
      release_held();
      if (rewritten_q.size() > first) begin
        tail = rewritten_q.pop_back();
        tail.fin = 1'b1;
        rewritten_q = {rewritten_q, tail};
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void send(input logic [7:0] c, input logic fin);
    text_word_t w;
    w.ch  = c;
    w.fin = fin;
    text_q = {text_q, w};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return 8'("0" + n);
    return 8'((upper ? "A" : "a") + n - 10);
  endfunction

  // one tag with alpha a and color bgr, digits in random case; cut >= 0 replaces
  // the byte at that position by cut_byte and ends the sequence there
  function automatic void add_tag(input logic [7:0] a, input logic [23:0] bgr, input int cut,
                                  input logic [7:0] cut_byte, input bit fin);
    logic [31:0] digits;
    logic [7:0]  c;
    int          k;
    int          stop;
    digits = {a, bgr};
    k = 0;
    stop = (cut >= 0) ? cut : TAG_LEN - 1;
    for (int i = 0; i <= stop; i++) begin
      c = TAG_SHAPE[i];
      if (c == "x") begin
        c = hex_char(digits[31 - 4 * k -: 4], $urandom_range(0, 1));
        k++;
      end
      if (i == cut) c = cut_byte;
      send(c, fin && (i == stop));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of words with random gaps, driven on the falling edge
  // ---------------------------------------------------------------------------
  bit         in_taken = 1'b0;   // word accepted at the last rising edge
  int         burst_left = 0;
  int         gap_left = 0;
  text_word_t next_word;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled word holds as it is
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (text_q.size() > 0) begin
      next_word = text_q.pop_front();
      char_in <= next_word.ch;
      last_in <= next_word.fin;
      in_valid <= 1'b1;
      if (burst_left > 0) burst_left--;
      else begin
        // some bursts are long and gapless, others choppy
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        gap_left = $urandom_range(0, 5);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, also on the falling edge
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= ((mode_left % 16) < 9);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input words, check output words, at the rising edge
  // ---------------------------------------------------------------------------
  text_word_t owed;

  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) rewrite_byte(char_in, last_in);
      if (out_valid && !out_stall) begin
        if (rewritten_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word char_out=%h last_out=%b", $time, char_out, last_out);
        end else begin
          owed = rewritten_q.pop_front();
          if (char_out !== owed.ch) begin
            errors++;
            $display("%0t: char_out expected %h actual %h", $time, owed.ch, char_out);
          end
          if (last_out !== owed.fin) begin
            errors++;
            $display("%0t: last_out expected %b actual %b", $time, owed.fin, last_out);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  int directed_words;
  int pick;
  int cut;

  initial begin
    // plain bytes at both ends of the range
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    // full tag, alpha 00 gives a two-byte 255, colors straddle 0x80
    add_tag(8'h00, 24'hFF807F, -1, 8'h00, 1'b0);
    // match broken at its very last byte by a new tag start: 23 held words out
    add_tag(8'h12, 24'h345678, TAG_LEN - 1, CH_LBRACE, 1'b0);
    // the new match is still open when the text ends
    send("\\", 1'b0);
    send("a", 1'b0);
    send("l", 1'b1);
    // full tag closing the text, alpha ff gives zero
    add_tag(8'hFF, 24'h00017F, -1, 8'h00, 1'b1);
    // short break, breaking byte outside ascii, then end of text on a plain byte
    add_tag(8'hAB, 24'hCDEF01, 5, 8'hC3, 1'b0);
    send("x", 1'b1);
    directed_words = text_q.size();

    // random part: well-formed tags in half the picks, broken tags and noise in the rest
    while (text_q.size() < directed_words + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_tag(8'($urandom), 24'($urandom), -1, 8'h00, $urandom_range(0, 4) == 0);
      end else if (pick < 75) begin
        cut = $urandom_range(1, TAG_LEN - 1);
        add_tag(8'($urandom), 24'($urandom), cut,
                ($urandom_range(0, 3) == 0) ? CH_LBRACE : 8'($urandom),
                $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 6))
          send(($urandom_range(0, 5) == 0) ? CH_LBRACE : 8'($urandom),
               $urandom_range(0, 9) == 0);
      end
    end
    // close the text so nothing stays held
    send(8'($urandom), 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: all words sent, then all owed words seen, then a short settle
    while (text_q.size() > 0 || in_valid) @(posedge clk);
    while (rewritten_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog well above the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
